// ===== hdl/gga_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the GB2312 glyph address generator.
// No dependencies; used by gga_decode, gga_addr and the top level.
package gga_pkg;

  localparam logic [7:0]  HANZI_LO     = 8'hB0;
  localparam logic [7:0]  HANZI_HI     = 8'hF7;
  localparam logic [7:0]  SYM_LO       = 8'hA1;
  localparam logic [7:0]  SYM_HI       = 8'hA3;
  localparam logic [7:0]  TRAIL_MIN    = 8'hA1;
  localparam logic [7:0]  ASCII_LO     = 8'h20;
  localparam logic [7:0]  ASCII_HI     = 8'h7E;
  localparam logic [15:0] ROW_CELLS    = 16'd94;
  localparam logic [15:0] HANZI_OFFSET = 16'd846;
  localparam logic [23:0] ASCII_BASE   = 24'h03CF80;
  localparam logic [7:0]  WIDE_STEP    = 8'd16;
  localparam logic [7:0]  NARROW_STEP  = 8'd8;
  localparam logic [3:0]  PAGE_RESET   = 4'd1;

  // One decoded glyph request travelling from the decoder to the address stage.
  typedef struct packed {
    logic       wide;
    logic [7:0] lead;
    logic [7:0] code;
    logic [3:0] page;
    logic [7:0] column;
  } glyph_req_t;

endpackage

// ===== hdl/gga_decode.sv =====
`timescale 1ns / 1ps
// Byte decoder: keeps the string state (held lead, page, column) and registers
// one glyph request per result-producing byte. Depends on gga_pkg.
module gga_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_start_flag,
  input  logic [3:0]          in_start_page,
  input  logic [7:0]          in_start_column,
  output logic                req_valid,
  input  logic                req_ready,
  output gga_pkg::glyph_req_t req
);

  logic [7:0] held_lead_r, held_lead_nxt;
  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] column_r, column_nxt;
  logic [3:0] page_r, page_nxt;
  logic       req_valid_r, req_valid_nxt;
  gga_pkg::glyph_req_t req_r, req_nxt;

  logic       accept;
  logic       pending_eff;
  logic [7:0] column_eff;
  logic [3:0] page_eff;
  logic       is_lead;
  logic       is_ascii;

  assign in_ready = !req_valid_r || req_ready;
  assign accept   = in_valid && in_ready;

  assign pending_eff = lead_pending_r && !in_start_flag;
  assign column_eff  = in_start_flag ? in_start_column : column_r;
  assign page_eff    = in_start_flag ? in_start_page : page_r;
  assign is_lead  = ((in_text_byte >= gga_pkg::HANZI_LO) && (in_text_byte <= gga_pkg::HANZI_HI))
                 || ((in_text_byte >= gga_pkg::SYM_LO) && (in_text_byte <= gga_pkg::SYM_HI));
  assign is_ascii = (in_text_byte >= gga_pkg::ASCII_LO) && (in_text_byte <= gga_pkg::ASCII_HI);

  always_comb begin
    held_lead_nxt    = held_lead_r;
    lead_pending_nxt = lead_pending_r;
    column_nxt       = column_r;
    page_nxt         = page_r;
    req_valid_nxt    = req_valid_r && !req_ready;
    req_nxt          = req_r;
    if (accept) begin
      page_nxt         = page_eff;
      column_nxt       = column_eff;
      lead_pending_nxt = 1'b0;
      held_lead_nxt    = 8'd0;
      req_nxt.lead     = held_lead_r;
      req_nxt.code     = in_text_byte;
      req_nxt.page     = page_eff;
      req_nxt.column   = column_eff;
      // A byte after a lead that is too small to be a trail drops the lead
      // and falls through to the single-byte cases.
      priority if (pending_eff && (in_text_byte >= gga_pkg::TRAIL_MIN)) begin
        req_nxt.wide  = 1'b1;
        req_valid_nxt = 1'b1;
        column_nxt    = column_eff + gga_pkg::WIDE_STEP;
      end else if (is_lead) begin
        held_lead_nxt    = in_text_byte;
        lead_pending_nxt = 1'b1;
      end else if (is_ascii) begin
        req_nxt.wide  = 1'b0;
        req_valid_nxt = 1'b1;
        column_nxt    = column_eff + gga_pkg::NARROW_STEP;
      end else begin
        req_nxt.wide = req_r.wide;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r    <= 8'd0;
      lead_pending_r <= 1'b0;
      column_r       <= 8'd0;
      page_r         <= gga_pkg::PAGE_RESET;
      req_valid_r    <= 1'b0;
    end else begin
      held_lead_r    <= held_lead_nxt;
      lead_pending_r <= lead_pending_nxt;
      column_r       <= column_nxt;
      page_r         <= page_nxt;
      req_valid_r    <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule

// ===== hdl/gga_addr.sv =====
`timescale 1ns / 1ps
// Address stage: turns a registered glyph request into a font ROM address and
// holds the result beat in the output register. Depends on gga_pkg.
module gga_addr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  gga_pkg::glyph_req_t req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [23:0]         out_font_address,
  output logic                out_glyph_wide,
  output logic [3:0]          out_glyph_page,
  output logic [7:0]          out_glyph_column
);

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic        wide_r;
  logic [3:0]  page_r;
  logic [7:0]  column_r;

  logic        hanzi;
  logic [7:0]  row;
  logic [15:0] glyph_index;
  logic [23:0] wide_addr;
  logic [23:0] narrow_addr;

  assign req_ready = !out_valid_r || out_ready;

  assign hanzi = req.lead >= gga_pkg::HANZI_LO;
  assign row   = hanzi ? (req.lead - gga_pkg::HANZI_LO) : (req.lead - gga_pkg::SYM_LO);
  // Hanzi rows sit after the symbol area, which takes the first 846 cells.
  assign glyph_index = ({8'd0, row} * gga_pkg::ROW_CELLS)
                     + {8'd0, req.code - gga_pkg::TRAIL_MIN}
                     + (hanzi ? gga_pkg::HANZI_OFFSET : 16'd0);
  assign wide_addr   = {3'd0, glyph_index, 5'd0};
  assign narrow_addr = {12'd0, req.code - gga_pkg::ASCII_LO, 4'd0} + gga_pkg::ASCII_BASE;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    addr_nxt      = addr_r;
    if (req_valid && req_ready) begin
      out_valid_nxt = 1'b1;
      addr_nxt      = req.wide ? wide_addr : narrow_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (req_valid && req_ready) begin
      wide_r   <= req.wide;
      page_r   <= req.page;
      column_r <= req.column;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_font_address = addr_r;
  assign out_glyph_wide   = wide_r;
  assign out_glyph_page   = page_r;
  assign out_glyph_column = column_r;

endmodule

// ===== hdl/gb2312_glyph_address_generator.sv =====
`timescale 1ns / 1ps
// GB2312 / ASCII glyph address generator, top level.
// Instantiates gga_decode and gga_addr; depends on gga_pkg.
//
// Usage:
//   The input channel (in_valid / in_ready) takes one text byte per beat with
//   its start flag, start page and start column. The result channel
//   (out_valid / out_ready) gives one glyph beat: font ROM address, width
//   flag, page and column. A printable ASCII byte or a lead byte followed by
//   a trail byte gives one result; other bytes give none.
//   A result passes two registers from the accepted byte (the trail byte
//   for a 16x16 glyph) to out_valid: one after the decoder, one after the
//   address multiply by 94. Throughput is one byte per cycle while the
//   receiver keeps out_ready high; both stages hold a beat and pass it on in
//   the same cycle they take the next. When the receiver stalls, the output
//   register holds its beat, then the decoder register fills, and in_ready
//   falls; nothing is lost. Reset (rst_n low, synchronous) empties both
//   stages, drops any held lead byte, and sets column 0 and page 1.
module gb2312_glyph_address_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_start_flag,
  input  logic [3:0]  in_start_page,
  input  logic [7:0]  in_start_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_font_address,
  output logic        out_glyph_wide,
  output logic [3:0]  out_glyph_page,
  output logic [7:0]  out_glyph_column
);

  logic                req_valid;
  logic                req_ready;
  gga_pkg::glyph_req_t req;

  gga_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_start_flag   (in_start_flag),
    .in_start_page   (in_start_page),
    .in_start_column (in_start_column),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req)
  );

  gga_addr u_addr (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req              (req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_font_address (out_font_address),
    .out_glyph_wide   (out_glyph_wide),
    .out_glyph_page   (out_glyph_page),
    .out_glyph_column (out_glyph_column)
  );

endmodule
